>>> src/pfc_pkg.sv
// shared types, widths and codes for the pid feedforward controller
package pfc_pkg;

  // default number of fraction bits in the gains
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // serial multiplier operand width and full product width
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // serial divider dividend and divisor widths
  localparam int DIV_N = 50;
  localparam int DIV_D = 16;

  // running sum of the four terms
  localparam int ACC_W = 56;

  // magnitude limit of the integral term
  localparam logic [PROD_W-1:0] I_LIMIT = PROD_W'(64'd2000000000);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_F     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_POINT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BAND = 3'd5;

  typedef struct packed {
    logic signed [15:0] measured_value;
    logic [15:0]        elapsed_ms;
  } pfc_in_t;

  typedef struct packed {
    logic signed [31:0] drive_value;
    logic               integral_cleared;
  } pfc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MWAIT,
    ST_DWAIT,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_INT,
    OP_P,
    OP_F,
    OP_I,
    OP_D
  } op_t;

endpackage

>>> src/pfc_mul.sv
// bit-serial shift-add multiplier for unsigned magnitudes
module pfc_mul
  import pfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_W + 1);

  logic [MUL_W:0]        hi_r;
  logic [MUL_W-1:0]      lo_r;
  logic [MUL_W-1:0]      a_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [MUL_W:0]        sum_nxt;
  logic [PROD_W:0]       shift_nxt;

  // add the multiplicand when the low multiplier bit is set
  always_comb begin
    sum_nxt   = lo_r[0] ? (hi_r + {1'b0, a_r}) : hi_r;
    shift_nxt = {sum_nxt, lo_r} >> 1;
  end

  // one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        hi_r   <= '0;
        lo_r   <= b;
        a_r    <= a;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        hi_r  <= shift_nxt[PROD_W:MUL_W];
        lo_r  <= shift_nxt[MUL_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r[MUL_W-1:0], lo_r};

endmodule

>>> src/pfc_div.sv
// bit-serial restoring divider for unsigned magnitudes
module pfc_div
  import pfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DIV_D-1:0] divisor,
  output logic             done,
  output logic [DIV_N-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_N + 1);

  logic [DIV_N-1:0] q_r;
  logic [DIV_D-1:0] rem_r;
  logic [DIV_D-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_D:0]   trial_nxt;
  logic [DIV_D:0]   diff_nxt;
  logic             bit_nxt;

  // shift in one dividend bit and try the subtraction
  always_comb begin
    trial_nxt = {rem_r, q_r[DIV_N-1]};
    diff_nxt  = trial_nxt - {1'b0, dvs_r};
    bit_nxt   = (trial_nxt >= {1'b0, dvs_r});
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= bit_nxt ? diff_nxt[DIV_D-1:0] : trial_nxt[DIV_D-1:0];
        q_r   <= {q_r[DIV_N-2:0], bit_nxt};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> src/pid_feedforward_controller.sv
// pid controller with set point feedforward, top level
// steps per accepted beat: five serial multiplies (integral update, P, F, I, D),
// a derivative divide (skipped, with no derivative term, when elapsed is zero), one output load
// a new beat is not taken until the previous result is loaded into the output register;
// in_stall is high until the result is loaded, and the next beat is taken while it waits
// reset (synchronous, active low) clears configuration registers, integral and last error
module pid_feedforward_controller
  import pfc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pfc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pfc_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // configuration registers
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r, gain_f_r;
  logic signed [15:0] set_point_r;
  logic [15:0]        error_band_r;

  // loop state
  logic signed [31:0] integral_r;
  logic signed [17:0] prev_err_r;

  // per item working registers
  state_t             state_r, state_nxt;
  op_t                op_r;
  logic signed [16:0] err_r;
  logic signed [17:0] diff_r;
  logic [15:0]        elapsed_r;
  logic               cleared_r;
  logic               sign_r;
  logic signed [ACC_W-1:0] acc_r;
  logic               out_valid_r;
  pfc_out_t           out_data_r;

  // combinational
  logic               in_acc;
  logic signed [16:0] err_nxt;
  logic [16:0]        err_mag;
  logic               mul_start, div_start;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic               sign_nxt;
  logic               mul_done, div_done;
  logic [PROD_W-1:0]  prod;
  logic [DIV_N-1:0]   quot;
  logic [PROD_W-1:0]  shifted;
  logic [ACC_W-1:0]   term_mag, iterm_mag, dterm_mag;
  logic [ACC_W-1:0]   term_s, iterm_s, dterm_s;
  logic [33:0]        iprod, iprod_s, isum;
  logic signed [31:0] isat;
  logic               out_free;
  logic               acc_fits;
  logic signed [31:0] drive;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      gain_f_r     <= '0;
      set_point_r  <= '0;
      error_band_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAIN_P:     gain_p_r     <= cfg_data;
        CFG_GAIN_I:     gain_i_r     <= cfg_data;
        CFG_GAIN_D:     gain_d_r     <= cfg_data;
        CFG_GAIN_F:     gain_f_r     <= cfg_data;
        CFG_SET_POINT:  set_point_r  <= cfg_data[15:0];
        CFG_ERROR_BAND: error_band_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // error of the incoming beat
  always_comb begin
    err_nxt = {set_point_r[15], set_point_r}
            - {in_data.measured_value[15], in_data.measured_value};
    err_mag = err_nxt[16] ? 17'(-err_nxt) : err_nxt;
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // serial arithmetic units
  pfc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  pfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (shifted[DIV_N-1:0]),
    .divisor  (elapsed_r),
    .done     (div_done),
    .quot     (quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MWAIT;
      ST_MWAIT: begin
        if (mul_done) begin
          if (op_r != OP_D) state_nxt = ST_LOAD;
          else if (elapsed_r != 16'd0) state_nxt = ST_DWAIT;
          else state_nxt = ST_FIN;
        end
      end
      ST_DWAIT: if (div_done) state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: operand selection and unit starts
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    mul_start = (state_r == ST_LOAD);
    div_start = (state_r == ST_MWAIT) && mul_done && (op_r == OP_D)
             && (elapsed_r != 16'd0);
    mul_a     = '0;
    mul_b     = '0;
    sign_nxt  = 1'b0;
    case (op_r)
      OP_INT: begin
        mul_a    = MUL_W'(err_r[16] ? 17'(-err_r) : err_r);
        mul_b    = MUL_W'(elapsed_r);
        sign_nxt = err_r[16];
      end
      OP_P: begin
        mul_a    = gain_p_r[31] ? 32'(-gain_p_r) : gain_p_r;
        mul_b    = MUL_W'(err_r[16] ? 17'(-err_r) : err_r);
        sign_nxt = gain_p_r[31] ^ err_r[16];
      end
      OP_F: begin
        mul_a    = gain_f_r[31] ? 32'(-gain_f_r) : gain_f_r;
        // zero-extend so the most negative set point keeps its magnitude
        mul_b    = {16'd0, set_point_r[15] ? 16'(-set_point_r) : set_point_r};
        sign_nxt = gain_f_r[31] ^ set_point_r[15];
      end
      OP_I: begin
        mul_a    = gain_i_r[31] ? 32'(-gain_i_r) : gain_i_r;
        mul_b    = integral_r[31] ? 32'(-integral_r) : integral_r;
        sign_nxt = gain_i_r[31] ^ integral_r[31];
      end
      OP_D: begin
        mul_a    = gain_d_r[31] ? 32'(-gain_d_r) : gain_d_r;
        mul_b    = MUL_W'(diff_r[17] ? 18'(-diff_r) : diff_r);
        sign_nxt = gain_d_r[31] ^ diff_r[17];
      end
      default: ;
    endcase
  end

  // term shaping: scale, clamp, sign
  always_comb begin
    shifted   = prod >> GAIN_FRAC_BITS;
    term_mag  = shifted[ACC_W-1:0];
    iterm_mag = (shifted > I_LIMIT) ? ACC_W'(I_LIMIT) : shifted[ACC_W-1:0];
    dterm_mag = ACC_W'(quot);
    term_s    = sign_r ? ACC_W'(-term_mag)  : term_mag;
    iterm_s   = sign_r ? ACC_W'(-iterm_mag) : iterm_mag;
    dterm_s   = sign_r ? ACC_W'(-dterm_mag) : dterm_mag;
    // integral update with 32-bit saturation
    iprod     = {1'b0, prod[32:0]};
    iprod_s   = sign_r ? 34'(-iprod) : iprod;
    isum      = {{2{integral_r[31]}}, integral_r} + iprod_s;
    if (isum[33:31] == 3'b000 || isum[33:31] == 3'b111) isat = isum[31:0];
    else if (isum[33]) isat = 32'sh8000_0000;
    else isat = 32'sh7FFF_FFFF;
    // final saturation
    acc_fits  = (acc_r[ACC_W-1:31] == {(ACC_W-31){acc_r[ACC_W-1]}});
    if (acc_fits) drive = acc_r[31:0];
    else if (acc_r[ACC_W-1]) drive = 32'sh8000_0000;
    else drive = 32'sh7FFF_FFFF;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // per item datapath and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_err_r <= '0;
      op_r       <= OP_INT;
    end else begin
      if (in_acc) begin
        err_r      <= err_nxt;
        diff_r     <= {err_nxt[16], err_nxt} - prev_err_r;
        prev_err_r <= {err_nxt[16], err_nxt};
        elapsed_r  <= in_data.elapsed_ms;
        cleared_r  <= (err_mag < {1'b0, error_band_r});
        acc_r      <= '0;
        op_r       <= OP_INT;
      end
      if (state_r == ST_LOAD) sign_r <= sign_nxt;
      if (state_r == ST_MWAIT && mul_done) begin
        case (op_r)
          OP_INT: begin
            integral_r <= cleared_r ? 32'sd0 : isat;
            op_r       <= OP_P;
          end
          OP_P: begin
            acc_r <= acc_r + term_s;
            op_r  <= OP_F;
          end
          OP_F: begin
            acc_r <= acc_r + term_s;
            op_r  <= OP_I;
          end
          OP_I: begin
            if (!cleared_r) acc_r <= acc_r + iterm_s;
            op_r <= OP_D;
          end
          default: ;
        endcase
      end
      if (state_r == ST_DWAIT && div_done) acc_r <= acc_r + dterm_s;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_FIN && out_free) begin
        out_valid_r                 <= 1'b1;
        out_data_r.drive_value      <= drive;
        out_data_r.integral_cleared <= cleared_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
